// ===== rtl/core/nlc_pkg.sv =====
// shared types and constants of the newline index line and column lookup
`timescale 1ns / 1ps

package nlc_pkg;

  localparam int unsigned TableEntries = 1024;
  localparam int unsigned OffsetBits   = 20;
  localparam int unsigned PosW         = OffsetBits + 1;
  localparam int unsigned LineW        = 11;
  localparam int unsigned LimitW       = 11;
  localparam int unsigned QueueDepth   = 4;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;
  localparam logic [1:0] CMD_QUERY = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_OVF   = 2'd2;

  localparam logic [7:0] NewlineChar = 8'h0a;
  localparam logic [LimitW-1:0] LimitReset = LimitW'(16);

  typedef struct packed {
    logic [1:0]            command;
    logic [7:0]            source_byte;
    logic [OffsetBits-1:0] query_offset;
    logic                  query_is_null;
  } in_item_t;

  typedef struct packed {
    logic [LineW-1:0] line_number;
    logic [PosW-1:0]  column_value;
    logic [1:0]       status;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_START,
    OP_BYTE,
    OP_END,
    OP_QUERY
  } op_e;

  // classified command handed from the front to the back
  typedef struct packed {
    op_e                   kind;
    logic                  is_newline;
    logic [OffsetBits-1:0] offset;
    logic                  is_null;
  } op_t;

endpackage

// ===== rtl/core/newline_index_line_column_lookup.sv =====
// top level of the newline index line and column lookup
`timescale 1ns / 1ps
// commands: start, byte and end commands retire one per cycle once dequeued, while the back end is idle
// query: a probe loop over the registered-read table, about
//   log2(entries)+1 probes by bisection or line+1 by linear scan, then a read of the previous
//   entry unless on line 0; null or rejected queries skip the loop and go straight to the result
// throughput: one source byte per cycle while no query is busy; queries are handled one at a time
// reset: control state clears at once; the table memory is not cleared and needs no pass

module newline_index_line_column_lookup #(
  parameter int unsigned TABLE_ENTRIES = nlc_pkg::TableEntries
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input beats
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  nlc_pkg::in_item_t          in_data_i,
  // result beats
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output nlc_pkg::out_item_t         out_data_o,
  // search mode limit register
  input  logic                       cfg_we_i,
  input  logic [nlc_pkg::LimitW-1:0] cfg_data_i
);

  // classified commands between front and back
  logic         op_valid;
  logic         op_ready;
  nlc_pkg::op_t op;

  // front: decodes the command and buffers beats so input keeps flowing
  // while the back end searches or a result waits
  nlc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .op_valid_o (op_valid),
    .op_ready_i (op_ready),
    .op_o       (op)
  );

  // back: table build, search sequencer and output register
  nlc_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (op_valid),
    .op_ready_o  (op_ready),
    .op_i        (op),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/core/nlc_ram.sv =====
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module nlc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/nlc_front.sv =====
// front end: accepts items, classifies them and queues them for the back end
`timescale 1ns / 1ps

module nlc_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  nlc_pkg::in_item_t in_data_i,
  output logic             op_valid_o,
  input  logic             op_ready_i,
  output nlc_pkg::op_t     op_o
);

  localparam int unsigned PtrW = $clog2(nlc_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(nlc_pkg::QueueDepth + 1);

  nlc_pkg::op_t  queue_q [nlc_pkg::QueueDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] fill_q;
  nlc_pkg::op_t  op_in;
  logic          push, pop;

  always_comb begin
    unique case (in_data_i.command)
      nlc_pkg::CMD_START: op_in.kind = nlc_pkg::OP_START;
      nlc_pkg::CMD_BYTE:  op_in.kind = nlc_pkg::OP_BYTE;
      nlc_pkg::CMD_END:   op_in.kind = nlc_pkg::OP_END;
      default:            op_in.kind = nlc_pkg::OP_QUERY;
    endcase
    op_in.is_newline = (in_data_i.source_byte == nlc_pkg::NewlineChar);
    op_in.offset     = in_data_i.query_offset;
    op_in.is_null    = in_data_i.query_is_null;
  end

  assign in_ready_o = (fill_q != CntW'(nlc_pkg::QueueDepth));
  assign op_valid_o = (fill_q != '0);
  assign op_o       = queue_q[rptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = op_valid_o && op_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wptr_q] <= op_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == PtrW'(nlc_pkg::QueueDepth - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (pop) begin
        rptr_q <= (rptr_q == PtrW'(nlc_pkg::QueueDepth - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        fill_q <= fill_q + CntW'(1);
      end else if (pop && !push) begin
        fill_q <= fill_q - CntW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/nlc_back.sv =====
// back end: builds the newline table and answers queries by table search
`timescale 1ns / 1ps

module nlc_back #(
  parameter int unsigned TABLE_ENTRIES = nlc_pkg::TableEntries
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       op_valid_i,
  output logic                       op_ready_o,
  input  nlc_pkg::op_t               op_i,
  input  logic                       cfg_we_i,
  input  logic [nlc_pkg::LimitW-1:0] cfg_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output nlc_pkg::out_item_t         out_data_o
);

  localparam int unsigned AW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned PosW = nlc_pkg::PosW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_PREV,
    S_DONE
  } state_e;

  state_e                     state_q;
  logic [CntW-1:0]            cnt_q, lo_q, n_q, half_q;
  logic [PosW-1:0]            pos_q, col_q;
  logic                       ovf_q, ended_q, lin_q;
  logic [nlc_pkg::LimitW-1:0] lim_q;
  logic [nlc_pkg::OffsetBits-1:0] off_q;
  logic [1:0]                 stat_q;
  logic                       out_valid_q;
  nlc_pkg::out_item_t         out_data_q;

  logic            pop;
  logic            emit;
  logic            byte_live, nl_write, end_write;
  logic [CntW-1:0] half_c, probe_sum;
  logic            we;
  logic [AW-1:0]   raddr;
  logic [PosW-1:0] rdata;
  logic [PosW-1:0] off_ext;

  assign op_ready_o = (state_q == S_IDLE);
  assign pop        = op_valid_i && op_ready_o;
  assign off_ext    = {1'b0, off_q};
  // result register takes a new beat when empty or draining this cycle
  assign emit       = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // a byte counts only before end of source and while the length is not saturated
  assign byte_live = pop && (op_i.kind == nlc_pkg::OP_BYTE) && !ended_q && !pos_q[PosW-1];
  // last slot stays free for the end entry
  assign nl_write  = byte_live && op_i.is_newline && (cnt_q < CntW'(TABLE_ENTRIES - 1));
  assign end_write = pop && (op_i.kind == nlc_pkg::OP_END) && !ended_q &&
                     (cnt_q < CntW'(TABLE_ENTRIES));
  assign we        = nl_write || end_write;

  // linear mode probes one entry at a time, bisection probes the middle
  assign half_c    = lin_q ? '0 : (n_q >> 1);
  assign probe_sum = lo_q + half_c;

  always_comb begin
    if (n_q == '0) begin
      raddr = AW'(lo_q - CntW'(1));
    end else begin
      raddr = AW'(probe_sum);
    end
  end

  nlc_ram #(
    .WIDTH (PosW),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (AW'(cnt_q)),
    .wdata_i (pos_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      pos_q       <= '0;
      ovf_q       <= 1'b0;
      ended_q     <= 1'b0;
      lim_q       <= nlc_pkg::LimitReset;
      lo_q        <= '0;
      n_q         <= '0;
      half_q      <= '0;
      lin_q       <= 1'b0;
      off_q       <= '0;
      col_q       <= '0;
      stat_q      <= nlc_pkg::ST_OK;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        lim_q <= cfg_data_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (pop) begin
            unique case (op_i.kind)
              nlc_pkg::OP_START: begin
                cnt_q   <= '0;
                pos_q   <= '0;
                ovf_q   <= 1'b0;
                ended_q <= 1'b0;
              end
              nlc_pkg::OP_BYTE: begin
                if (!ended_q) begin
                  if (pos_q[PosW-1]) begin
                    ovf_q <= 1'b1;
                  end else begin
                    pos_q <= pos_q + PosW'(1);
                    if (nl_write) begin
                      cnt_q <= cnt_q + CntW'(1);
                    end else if (op_i.is_newline) begin
                      ovf_q <= 1'b1;
                    end
                  end
                end
              end
              nlc_pkg::OP_END: begin
                if (end_write) begin
                  cnt_q <= cnt_q + CntW'(1);
                end
                ended_q <= 1'b1;
              end
              default: begin
                off_q <= op_i.offset;
                lo_q  <= '0;
                col_q <= '0;
                if (op_i.is_null) begin
                  stat_q  <= nlc_pkg::ST_OK;
                  state_q <= S_DONE;
                end else if (!ended_q || ({1'b0, op_i.offset} >= pos_q)) begin
                  stat_q  <= nlc_pkg::ST_RANGE;
                  state_q <= S_DONE;
                end else begin
                  stat_q  <= ovf_q ? nlc_pkg::ST_OVF : nlc_pkg::ST_OK;
                  n_q     <= cnt_q;
                  lin_q   <= (32'(cnt_q) < 32'(lim_q));
                  state_q <= S_PROBE;
                end
              end
            endcase
          end
        end
        S_PROBE: begin
          if (n_q != '0) begin
            half_q  <= half_c;
            state_q <= S_CMP;
          end else if (lo_q == '0) begin
            // line 0: column is the offset itself
            col_q   <= off_ext;
            state_q <= S_DONE;
          end else begin
            state_q <= S_PREV;
          end
        end
        S_CMP: begin
          if (rdata <= off_ext) begin
            lo_q <= lo_q + half_q + CntW'(1);
            n_q  <= n_q - half_q - CntW'(1);
          end else begin
            n_q <= half_q;
          end
          state_q <= S_PROBE;
        end
        S_PREV: begin
          col_q   <= off_ext - rdata + PosW'(1);
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (emit) begin
            out_data_q.line_number  <= nlc_pkg::LineW'(lo_q);
            out_data_q.column_value <= col_q;
            out_data_q.status       <= stat_q;
            state_q                 <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/core/nlc_checker.sv =====
// port level checks of the newline index line and column lookup
`timescale 1ns / 1ps

module nlc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input nlc_pkg::out_item_t out_data_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status == nlc_pkg::ST_OK ||
      out_data_o.status == nlc_pkg::ST_RANGE || out_data_o.status == nlc_pkg::ST_OVF)
    else $error("illegal status code");

  // rejected queries carry zero position
  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == nlc_pkg::ST_RANGE |->
      out_data_o.line_number == '0 && out_data_o.column_value == '0)
    else $error("rejected query with nonzero position");

  // on line 0 the column is the offset, which fits the offset width
  a_line0_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.line_number == '0 |->
      out_data_o.column_value[nlc_pkg::OffsetBits] == 1'b0)
    else $error("line 0 column exceeds offset range");

endmodule

bind newline_index_line_column_lookup nlc_checker u_nlc_checker (.*);

// ===== tb/newline_index_line_column_lookup_test.sv =====
// self-checking testbench of the newline index line and column lookup
`timescale 1ns / 1ps

module newline_index_line_column_lookup_test;

  // run control
  localparam int unsigned SettleCycles = 24;
  localparam logic [nlc_pkg::PosW-1:0] SourceCap =
    nlc_pkg::PosW'(1) << nlc_pkg::OffsetBits;
  localparam int unsigned PhaseBeats = 30;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  nlc_pkg::in_item_t  in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  nlc_pkg::out_item_t out_data_o;
  logic               cfg_we_i;
  logic [nlc_pkg::LimitW-1:0] cfg_data_i;

  // shadow of the block: newline positions, length and flags of the current source
  logic [nlc_pkg::PosW-1:0] nl_pos [nlc_pkg::TableEntries];
  int unsigned              nl_count;
  logic [nlc_pkg::PosW-1:0] src_len;
  bit                       ovf;
  bit                       ended;

  // line and column answers still owed by the block, oldest first
  nlc_pkg::out_item_t pending_locations [$];
  nlc_pkg::out_item_t want;

  int unsigned mismatch_count;
  int unsigned working_beats;
  int unsigned tx_gap_max = 15;
  int unsigned rx_gap_max = 15;
  int unsigned rx_hold_cycles;
  bit          offering;

  newline_index_line_column_lookup i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // apply one accepted beat to the shadow state; queries queue their answer
  // returns 0 when the block just ignores the beat
  function automatic bit track_beat(nlc_pkg::in_item_t beat);
    nlc_pkg::out_item_t found;
    int unsigned        idx;
    bit                 used;
    used = 1'b1;
    case (beat.command)
      nlc_pkg::CMD_START: begin
        nl_count = 0;
        src_len  = '0;
        ovf      = 1'b0;
        ended    = 1'b0;
      end
      nlc_pkg::CMD_BYTE: begin
        if (ended) begin
          used = 1'b0;
        end else if (src_len >= SourceCap) begin
          // length saturated, byte dropped
          ovf = 1'b1;
        end else begin
          if (beat.source_byte == nlc_pkg::NewlineChar) begin
            // last slot stays free for the end entry
            if (nl_count < nlc_pkg::TableEntries - 1) begin
              nl_pos[nl_count] = src_len;
              nl_count++;
            end else begin
              ovf = 1'b1;
            end
          end
          src_len++;
        end
      end
      nlc_pkg::CMD_END: begin
        if (ended) begin
          used = 1'b0;
        end else begin
          if (nl_count < nlc_pkg::TableEntries) begin
            nl_pos[nl_count] = src_len;
            nl_count++;
          end
          ended = 1'b1;
        end
      end
      nlc_pkg::CMD_QUERY: begin
        found = '0;
        if (beat.query_is_null) begin
          found.status = nlc_pkg::ST_OK;
        end else if (!ended || {1'b0, beat.query_offset} >= src_len) begin
          found.status = nlc_pkg::ST_RANGE;
        end else begin
          // line is the first entry strictly above the offset
          idx = 0;
          while (idx < nl_count && nl_pos[idx] <= {1'b0, beat.query_offset}) idx++;
          found.line_number = nlc_pkg::LineW'(idx);
          if (idx == 0) begin
            found.column_value = nlc_pkg::PosW'(beat.query_offset);
          end else begin
            found.column_value = nlc_pkg::PosW'(beat.query_offset) - nl_pos[idx-1] +
                                 nlc_pkg::PosW'(1);
          end
          found.status = ovf ? nlc_pkg::ST_OVF : nlc_pkg::ST_OK;
        end
        pending_locations.push_back(found);
      end
    endcase
    return used;
  endfunction

  // every field random, the caller fixes what matters
  function automatic nlc_pkg::in_item_t make_beat(logic [1:0] cmd);
    nlc_pkg::in_item_t beat;
    beat.command       = cmd;
    beat.source_byte   = 8'($urandom);
    beat.query_offset  = nlc_pkg::OffsetBits'($urandom);
    beat.query_is_null = 1'($urandom);
    return beat;
  endfunction

  // offsets mostly inside the source, some at or past its end
  function automatic logic [nlc_pkg::OffsetBits-1:0] pick_offset();
    int unsigned span;
    span = int'(src_len);
    case ($urandom_range(0, 9))
      0: return nlc_pkg::OffsetBits'($urandom);
      1: return '1;
      2: return nlc_pkg::OffsetBits'(span);
      default: begin
        if (span == 0) return nlc_pkg::OffsetBits'($urandom);
        return nlc_pkg::OffsetBits'($urandom_range(0, span - 1));
      end
    endcase
  endfunction

  // one input beat: random gap, then hold valid until taken
  task automatic send_beat(nlc_pkg::in_item_t beat);
    int unsigned gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap != 0) begin
      if (offering) begin
        in_valid_i <= 1'b0;
        offering = 1'b0;
      end
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    offering = 1'b1;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    if (track_beat(beat)) working_beats++;
  endtask

  task automatic send_cmd(logic [1:0] cmd);
    send_beat(make_beat(cmd));
  endtask

  task automatic send_char(logic [7:0] c);
    nlc_pkg::in_item_t beat;
    beat = make_beat(nlc_pkg::CMD_BYTE);
    beat.source_byte = c;
    send_beat(beat);
  endtask

  task automatic send_query(logic [nlc_pkg::OffsetBits-1:0] off, logic is_null);
    nlc_pkg::in_item_t beat;
    beat = make_beat(nlc_pkg::CMD_QUERY);
    beat.query_offset  = off;
    beat.query_is_null = is_null;
    send_beat(beat);
  endtask

  // sender stops and waits for every owed answer
  task automatic wait_for_results();
    if (offering) begin
      in_valid_i <= 1'b0;
      offering = 1'b0;
    end
    while (pending_locations.size() != 0) @(posedge clk_i);
  endtask

  // fully idle: answers in and non-query beats retired
  task automatic quiesce();
    wait_for_results();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_search_limit(logic [nlc_pkg::LimitW-1:0] limit);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= limit;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // hand-picked source with every special case of a query
  task automatic test_directed();
    send_query('1, 1'b1);            // null query with nothing loaded
    send_query(20'd5, 1'b0);         // query before any end of source
    send_cmd(nlc_pkg::CMD_START);
    send_char(8'h61);
    send_char(nlc_pkg::NewlineChar);
    send_char(8'hff);
    send_char(8'h00);
    send_char(nlc_pkg::NewlineChar);
    send_char(nlc_pkg::NewlineChar); // empty line
    send_char(8'h80);
    send_query(20'd3, 1'b0);         // source still open
    send_cmd(nlc_pkg::CMD_END);
    send_cmd(nlc_pkg::CMD_END);      // repeated end, ignored
    send_char(nlc_pkg::NewlineChar); // byte after end, ignored
    send_query(20'd0, 1'b0);
    send_query(20'd1, 1'b0);         // on a newline itself
    send_query(20'd2, 1'b0);
    send_query(20'd5, 1'b0);
    send_query(20'd6, 1'b0);         // last character
    send_query(20'd7, 1'b0);         // exactly the source length
    send_query('1, 1'b0);            // largest offset
    send_query(20'd3, 1'b1);
    // empty source answers out of range
    send_cmd(nlc_pkg::CMD_START);
    send_cmd(nlc_pkg::CMD_END);
    send_query(20'd0, 1'b0);
    quiesce();
  endtask

  // one source with random text and queries, sometimes broken on purpose
  task automatic run_session(int unsigned max_len);
    int unsigned len;
    int unsigned odds;
    int unsigned nq;
    if ($urandom_range(0, 9) != 0) send_cmd(nlc_pkg::CMD_START);
    len  = $urandom_range(0, max_len);
    odds = $urandom_range(1, 8);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 29) == 0) begin
        send_query(nlc_pkg::OffsetBits'($urandom), 1'($urandom));
      end
      if ($urandom_range(0, 59) == 0) send_cmd(nlc_pkg::CMD_START);
      if ($urandom_range(1, odds) == 1) send_char(nlc_pkg::NewlineChar);
      else send_char(8'($urandom));
    end
    if ($urandom_range(0, 11) != 0) send_cmd(nlc_pkg::CMD_END);
    if ($urandom_range(0, 7) == 0) send_cmd(nlc_pkg::CMD_END);
    if ($urandom_range(0, 7) == 0) send_char(8'($urandom));
    nq = $urandom_range(1, 8);
    for (int i = 0; i < nq; i++) send_query(pick_offset(), $urandom_range(0, 9) == 0);
  endtask

  // random sources under several search limits, extremes included
  task automatic test_random_sources();
    logic [nlc_pkg::LimitW-1:0] limits [6];
    int unsigned                mark;
    limits = '{nlc_pkg::LimitW'(0), nlc_pkg::LimitW'(1025), nlc_pkg::LimitW'(1023),
               nlc_pkg::LimitReset, nlc_pkg::LimitW'($urandom_range(1, 1025)),
               nlc_pkg::LimitW'($urandom_range(0, 64))};
    foreach (limits[p]) begin
      quiesce();
      set_search_limit(limits[p]);
      mark = working_beats;
      while (working_beats - mark < PhaseBeats) begin
        // some sessions run with no idling on one side or both
        tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
        rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
        run_session(($urandom_range(0, 9) == 0) ? 300 : 40);
        if ($urandom_range(0, 7) == 0) wait_for_results();
      end
    end
    tx_gap_max = 15;
    rx_gap_max = 15;
    quiesce();
  endtask

  // receiver holds off long enough for the block to stall its input
  task automatic test_receiver_holdoff();
    tx_gap_max = 0;
    rx_hold_cycles = 600;
    send_cmd(nlc_pkg::CMD_START);
    for (int i = 0; i < 24; i++) begin
      send_char((i % 5 == 4) ? nlc_pkg::NewlineChar : 8'($urandom));
    end
    send_cmd(nlc_pkg::CMD_END);
    for (int i = 0; i < 30; i++) send_query(pick_offset(), 1'b0);
    tx_gap_max = 15;
    quiesce();
  endtask

  // more newlines than the table holds, answered by scan and by bisection
  task automatic test_table_overflow();
    set_search_limit(nlc_pkg::LimitW'(1025));
    tx_gap_max = 3;
    send_cmd(nlc_pkg::CMD_START);
    for (int i = 0; i < 1060; i++) begin
      if (i % 40 == 39) send_char(8'($urandom_range(11, 255)));
      else send_char(nlc_pkg::NewlineChar);
    end
    send_cmd(nlc_pkg::CMD_END);
    for (int i = 0; i < 6; i++) send_query(pick_offset(), 1'b0);
    send_query(nlc_pkg::OffsetBits'(src_len - 1), 1'b0);
    quiesce();
    set_search_limit(nlc_pkg::LimitW'(0));
    for (int i = 0; i < 6; i++) send_query(pick_offset(), 1'b0);
    send_query(nlc_pkg::OffsetBits'(src_len - 1), 1'b0);
    tx_gap_max = 15;
    quiesce();
  endtask

  // receiver: random stall per beat, plus an occasional long hold-off
  initial begin : receiver
    int unsigned pause;
    forever begin
      pause = $urandom_range(0, rx_gap_max) + rx_hold_cycles;
      rx_hold_cycles = 0;
      if (pause != 0) begin
        out_ready_i <= 1'b0;
        repeat (pause) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  // each answer against the oldest owed one, field by field
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      if (pending_locations.size() == 0) begin
        $display("%0t: unexpected beat: line %0d column %0d status %0d", $time,
                 out_data_o.line_number, out_data_o.column_value, out_data_o.status);
        mismatch_count++;
      end else begin
        want = pending_locations.pop_front();
        if (out_data_o.line_number !== want.line_number) begin
          $display("%0t: line_number expected %0d actual %0d", $time,
                   want.line_number, out_data_o.line_number);
          mismatch_count++;
        end
        if (out_data_o.column_value !== want.column_value) begin
          $display("%0t: column_value expected %0d actual %0d", $time,
                   want.column_value, out_data_o.column_value);
          mismatch_count++;
        end
        if (out_data_o.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   want.status, out_data_o.status);
          mismatch_count++;
        end
      end
    end
  end

  // main sequence
  initial begin
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    cfg_we_i   <= 1'b0;
    cfg_data_i <= '0;
    rst_ni     <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_sources();
    test_receiver_holdoff();
    test_table_overflow();
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // hang guard, several times the slowest passing run
  initial begin
    #200_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/nlc_pkg.sv
rtl/core/nlc_ram.sv
rtl/core/nlc_front.sv
rtl/core/nlc_back.sv
rtl/core/newline_index_line_column_lookup.sv
rtl/core/nlc_checker.sv
tb/newline_index_line_column_lookup_test.sv
